// File: hdl/tbsm_pkg.sv
// Shared types, codes and helpers for the triple buffer slot manager.
`default_nettype none

package tbsm_pkg;

    localparam int COUNTER_WIDTH_DEFAULT = 32;
    localparam int SIZE_WIDTH_DEFAULT    = 16;
    localparam int NUM_COUNTERS          = 7;
    localparam int CNT_INDEX_WIDTH       = 3;
    localparam int CFG_DATA_WIDTH        = 16;
    localparam int CFG_INDEX_WIDTH       = 1;

    localparam logic [2:0] ALL_FREE = 3'h7;

    // Opcodes
    localparam logic [2:0] OP_BEGIN_WRITE = 3'd0;
    localparam logic [2:0] OP_ABORT       = 3'd1;
    localparam logic [2:0] OP_COMMIT      = 3'd2;
    localparam logic [2:0] OP_ACQUIRE     = 3'd3;
    localparam logic [2:0] OP_READ_CNT    = 3'd4;

    // Status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_INVALID_ARG = 3'd1;
    localparam logic [2:0] ST_BUSY        = 3'd2;
    localparam logic [2:0] ST_STATE_ERR   = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND   = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MAX_BYTES = 1'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MIN_BYTES = 1'd1;

    localparam logic [15:0] MAX_BYTES_RESET = 16'd4096;
    localparam logic [15:0] MIN_BYTES_RESET = 16'd16;

    // Usage counter indexes
    localparam int CNT_BEGINS    = 0;
    localparam int CNT_BUSY      = 1;
    localparam int CNT_PUBLISHED = 2;
    localparam int CNT_REPLACED  = 3;
    localparam int CNT_ACQUIRED  = 4;
    localparam int CNT_REUSED    = 5;
    localparam int CNT_RETURNED  = 6;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [1:0]  packet_slot;
        logic [15:0] packet_len;
        logic        checked;
        logic        packet_valid;
        logic [2:0]  counter_index;
    } request_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  slot_out;
        logic [15:0] size_out;
        logic [31:0] counter_value;
    } result_t;

    // One-hot free-mask bit of a slot number; slot zero has none.
    function automatic logic [2:0] slot_mask(input logic [1:0] slot);
        logic [2:0] m;
        begin
            case (slot)
                2'd1:    m = 3'b001;
                2'd2:    m = 3'b010;
                2'd3:    m = 3'b100;
                default: m = 3'b000;
            endcase
            return m;
        end
    endfunction

    // Lowest free slot number, zero when the mask is empty.
    function automatic logic [1:0] lowest_free(input logic [2:0] mask);
        logic [1:0] s;
        begin
            if (mask[0])
                s = 2'd1;
            else if (mask[1])
                s = 2'd2;
            else if (mask[2])
                s = 2'd3;
            else
                s = 2'd0;
            return s;
        end
    endfunction

endpackage

`default_nettype wire

// File: hdl/tbsm_counters.sv
// Usage counter bank: seven wrapping counters with a single read port.
`default_nettype none

module tbsm_counters #(
    parameter int COUNTER_WIDTH = tbsm_pkg::COUNTER_WIDTH_DEFAULT
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic [tbsm_pkg::NUM_COUNTERS-1:0]      bump,
    input  wire logic [tbsm_pkg::CNT_INDEX_WIDTH-1:0]   read_index,
    output logic      [COUNTER_WIDTH-1:0]               read_value
);

    logic [COUNTER_WIDTH-1:0] counter_reg [tbsm_pkg::NUM_COUNTERS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tbsm_pkg::NUM_COUNTERS; i++)
                counter_reg[i] <= '0;
        end
        else
        begin
            for (int i = 0; i < tbsm_pkg::NUM_COUNTERS; i++)
                if (bump[i])
                    counter_reg[i] <= counter_reg[i] + COUNTER_WIDTH'(1);
        end
    end

    // Index seven names no counter and reads as zero.
    always_comb
    begin
        if (read_index < tbsm_pkg::CNT_INDEX_WIDTH'(tbsm_pkg::NUM_COUNTERS))
            read_value = counter_reg[read_index];
        else
            read_value = '0;
    end

endmodule

`default_nettype wire

// File: hdl/triple_buffer_slot_manager_top.sv
// Top level: request register, slot bookkeeping and result register.
// Each accepted request passes the request register, then the result register, before its result strobe.
// Throughput: one request per cycle; busy stays low, as each request's bookkeeping is one
// combinational pass between the request register and the result register.
// Results are shown for exactly one cycle; the receiver cannot stall them.
// Reset: all slots free, no write, pending, active or retired slot, empty mailbox,
// sizes and counters zero, limits 4096 and 16 bytes.
`default_nettype none

module triple_buffer_slot_manager_top #(
    parameter int COUNTER_WIDTH = tbsm_pkg::COUNTER_WIDTH_DEFAULT,
    parameter int SIZE_WIDTH    = tbsm_pkg::SIZE_WIDTH_DEFAULT
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   start,
    output logic                                        busy,
    input  wire tbsm_pkg::request_t                     request,
    output logic                                        done,
    output tbsm_pkg::result_t                           result,
    input  wire logic                                   cfg_write,
    input  wire logic [tbsm_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  wire logic [tbsm_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);

    logic                     in_valid_reg;
    tbsm_pkg::request_t       in_reg;
    logic                     done_reg;
    tbsm_pkg::result_t        result_reg;
    tbsm_pkg::result_t        result_next;

    logic [15:0]              max_bytes_reg;
    logic [15:0]              min_bytes_reg;

    logic [2:0]               free_reg,     free_next;
    logic [1:0]               write_reg,    write_next;
    logic [1:0]               pending_reg,  pending_next;
    logic [1:0]               active_reg,   active_next;
    logic [1:0]               retired_reg,  retired_next;
    logic [1:0]               mailbox_reg,  mailbox_next;
    logic [SIZE_WIDTH-1:0]    size_reg [3];

    logic                     size_we;
    logic [1:0]               size_waddr;
    logic [tbsm_pkg::NUM_COUNTERS-1:0] bump;
    logic [COUNTER_WIDTH-1:0] cnt_value;
    logic [2:0]               free_tmp;
    logic [1:0]               grant;

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

    // Request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
            in_reg <= request;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_bytes_reg <= tbsm_pkg::MAX_BYTES_RESET;
            min_bytes_reg <= tbsm_pkg::MIN_BYTES_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                tbsm_pkg::CFG_MAX_BYTES: max_bytes_reg <= cfg_data;
                tbsm_pkg::CFG_MIN_BYTES: min_bytes_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    tbsm_counters #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_counters (
        .clk        (clk),
        .rst_n      (rst_n),
        .bump       (bump),
        .read_index (in_reg.counter_index),
        .read_value (cnt_value)
    );

    // Slot bookkeeping for the registered request
    always_comb
    begin
        free_next    = free_reg;
        write_next   = write_reg;
        pending_next = pending_reg;
        active_next  = active_reg;
        retired_next = retired_reg;
        mailbox_next = mailbox_reg;
        size_we      = 1'b0;
        size_waddr   = in_reg.packet_slot - 2'd1;
        bump         = '0;
        free_tmp     = free_reg | tbsm_pkg::slot_mask(mailbox_reg);
        grant        = tbsm_pkg::lowest_free(free_tmp);
        result_next  = '0;

        if (in_valid_reg)
        begin
            unique case (in_reg.opcode)
                tbsm_pkg::OP_BEGIN_WRITE:
                begin
                    if (write_reg != 2'd0)
                    begin
                        bump[tbsm_pkg::CNT_BUSY] = 1'b1;
                        result_next.status       = tbsm_pkg::ST_BUSY;
                    end
                    else
                    begin
                        // Drain the mailbox before picking a slot.
                        mailbox_next = 2'd0;
                        free_next    = free_tmp;
                        if (free_tmp == 3'd0)
                        begin
                            bump[tbsm_pkg::CNT_BUSY] = 1'b1;
                            result_next.status       = tbsm_pkg::ST_BUSY;
                        end
                        else
                        begin
                            write_next                 = grant;
                            free_next                  = free_tmp & ~tbsm_pkg::slot_mask(grant);
                            bump[tbsm_pkg::CNT_BEGINS] = 1'b1;
                            result_next.slot_out       = grant;
                        end
                    end
                end
                tbsm_pkg::OP_ABORT:
                begin
                    if (in_reg.packet_slot == 2'd0 || in_reg.packet_slot != write_reg)
                        result_next.status = tbsm_pkg::ST_STATE_ERR;
                    else
                    begin
                        free_next  = free_reg | tbsm_pkg::slot_mask(write_reg);
                        write_next = 2'd0;
                    end
                end
                tbsm_pkg::OP_COMMIT:
                begin
                    if (in_reg.packet_slot == 2'd0 || in_reg.packet_slot != write_reg ||
                        in_reg.packet_len < min_bytes_reg ||
                        in_reg.packet_len > max_bytes_reg)
                        result_next.status = tbsm_pkg::ST_STATE_ERR;
                    else if (in_reg.checked && !in_reg.packet_valid)
                        result_next.status = tbsm_pkg::ST_INVALID_ARG;
                    else
                    begin
                        size_we = 1'b1;
                        if (pending_reg != 2'd0)
                        begin
                            free_next = free_reg | tbsm_pkg::slot_mask(pending_reg);
                            bump[tbsm_pkg::CNT_REPLACED] = 1'b1;
                        end
                        pending_next                  = in_reg.packet_slot;
                        write_next                    = 2'd0;
                        bump[tbsm_pkg::CNT_PUBLISHED] = 1'b1;
                    end
                end
                tbsm_pkg::OP_ACQUIRE:
                begin
                    if (retired_reg != 2'd0 && mailbox_reg != 2'd0)
                        result_next.status = tbsm_pkg::ST_STATE_ERR;
                    else
                    begin
                        // Hand back the retired slot, then take the pending one.
                        if (retired_reg != 2'd0)
                        begin
                            mailbox_next                 = retired_reg;
                            retired_next                 = 2'd0;
                            bump[tbsm_pkg::CNT_RETURNED] = 1'b1;
                        end
                        if (pending_reg != 2'd0)
                        begin
                            retired_next                 = active_reg;
                            active_next                  = pending_reg;
                            pending_next                 = 2'd0;
                            bump[tbsm_pkg::CNT_ACQUIRED] = 1'b1;
                        end
                        else if (active_reg != 2'd0)
                            bump[tbsm_pkg::CNT_REUSED] = 1'b1;

                        if (active_next == 2'd0)
                            result_next.status = tbsm_pkg::ST_NOT_FOUND;
                        else
                        begin
                            result_next.slot_out = active_next;
                            result_next.size_out = 16'(size_reg[active_next - 2'd1]);
                        end
                    end
                end
                tbsm_pkg::OP_READ_CNT:
                    result_next.counter_value = 32'(cnt_value);
                default:
                    result_next.status = tbsm_pkg::ST_INVALID_ARG;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg    <= tbsm_pkg::ALL_FREE;
            write_reg   <= 2'd0;
            pending_reg <= 2'd0;
            active_reg  <= 2'd0;
            retired_reg <= 2'd0;
            mailbox_reg <= 2'd0;
            done_reg    <= 1'b0;
        end
        else
        begin
            free_reg    <= free_next;
            write_reg   <= write_next;
            pending_reg <= pending_next;
            active_reg  <= active_next;
            retired_reg <= retired_next;
            mailbox_reg <= mailbox_next;
            done_reg    <= in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
                size_reg[i] <= '0;
        end
        else if (size_we)
            size_reg[size_waddr] <= SIZE_WIDTH'(in_reg.packet_len);
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    // A slot being written is never in the free mask.
    a_write_not_free: assert property (@(posedge clk) disable iff (!rst_n)
        write_reg != 2'd0 |-> (free_reg & tbsm_pkg::slot_mask(write_reg)) == 3'd0)
        else $error("write slot marked free");

    // Pending and active slots are distinct when both exist.
    a_pending_active: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd0 && active_reg != 2'd0 |-> pending_reg != active_reg)
        else $error("pending slot equals active slot");

    // A slot in the mailbox is neither active nor pending.
    a_mailbox_owner: assert property (@(posedge clk) disable iff (!rst_n)
        mailbox_reg != 2'd0 |-> mailbox_reg != active_reg && mailbox_reg != pending_reg)
        else $error("mailbox slot still in use");

    // Every registered request produces exactly one result strobe next cycle.
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg |=> done_reg)
        else $error("result strobe missing");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |=> !done_reg)
        else $error("result strobe without request");

endmodule

`default_nettype wire

// File: dv/testbench.sv
// Testbench for the triple buffer slot manager: directed table, random traffic, result checks.
`timescale 1ns / 100ps

module testbench;
    import tbsm_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 115;
    localparam int NUM_PHASES  = 7;
    localparam int DRAIN_WAIT  = 6;

    // Opcodes outside the defined set, and the counter index past the last counter
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
    localparam logic [2:0] CNT_NONE       = 3'd7;

    typedef struct {
        request_t req;
        bit       typed;
        result_t  want;
    } dir_row_t;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    request_t request;
    logic     done;
    result_t  result;
    logic     cfg_write;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data;

    triple_buffer_slot_manager_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the slot bookkeeping
    logic [2:0]  free_mask;
    logic [1:0]  wr_slot;
    logic [1:0]  pend_slot;
    logic [1:0]  act_slot;
    logic [1:0]  ret_slot;
    logic [1:0]  mailbox;
    logic [15:0] slot_bytes [1:3];
    logic [31:0] usage_cnt [0:NUM_COUNTERS-1];
    logic [15:0] lim_max;
    logic [15:0] lim_min;

    result_t  slot_replies_due [$];
    dir_row_t directed_rows [$];
    int       fail_count;
    int       cycle_count;

    initial clk = 1'b0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [2:0] slot_bit(logic [1:0] slot);
        return (slot == 2'd0) ? 3'b000 : (3'b001 << (slot - 2'd1));
    endfunction

    // Advance the shadow state by one request and return the reply it should produce.
    function automatic result_t apply_slot_op(request_t r);
        result_t o;
        o = '0;
        case (r.opcode)
            OP_BEGIN_WRITE: begin
                if (wr_slot != 2'd0) begin
                    usage_cnt[CNT_BUSY] += 1;
                    o.status = ST_BUSY;
                end else begin
                    free_mask |= slot_bit(mailbox);
                    mailbox = 2'd0;
                    if (free_mask == 3'b000) begin
                        usage_cnt[CNT_BUSY] += 1;
                        o.status = ST_BUSY;
                    end else begin
                        wr_slot = free_mask[0] ? 2'd1 : (free_mask[1] ? 2'd2 : 2'd3);
                        free_mask &= ~slot_bit(wr_slot);
                        usage_cnt[CNT_BEGINS] += 1;
                        o.slot_out = wr_slot;
                    end
                end
            end
            OP_ABORT: begin
                if (r.packet_slot == 2'd0 || r.packet_slot != wr_slot) begin
                    o.status = ST_STATE_ERR;
                end else begin
                    free_mask |= slot_bit(wr_slot);
                    wr_slot = 2'd0;
                end
            end
            OP_COMMIT: begin
                if (r.packet_slot == 2'd0 || r.packet_slot != wr_slot ||
                    r.packet_len < lim_min || r.packet_len > lim_max) begin
                    o.status = ST_STATE_ERR;
                end else if (r.checked && !r.packet_valid) begin
                    o.status = ST_INVALID_ARG;
                end else begin
                    slot_bytes[r.packet_slot] = r.packet_len;
                    if (pend_slot != 2'd0) begin
                        free_mask |= slot_bit(pend_slot);
                        usage_cnt[CNT_REPLACED] += 1;
                    end
                    pend_slot = r.packet_slot;
                    wr_slot = 2'd0;
                    usage_cnt[CNT_PUBLISHED] += 1;
                end
            end
            OP_ACQUIRE: begin
                if (ret_slot != 2'd0 && mailbox != 2'd0) begin
                    o.status = ST_STATE_ERR;
                end else begin
                    if (ret_slot != 2'd0) begin
                        mailbox = ret_slot;
                        ret_slot = 2'd0;
                        usage_cnt[CNT_RETURNED] += 1;
                    end
                    if (pend_slot != 2'd0) begin
                        ret_slot = act_slot;
                        act_slot = pend_slot;
                        pend_slot = 2'd0;
                        usage_cnt[CNT_ACQUIRED] += 1;
                    end else if (act_slot != 2'd0) begin
                        usage_cnt[CNT_REUSED] += 1;
                    end
                    if (act_slot == 2'd0) begin
                        o.status = ST_NOT_FOUND;
                    end else begin
                        o.slot_out = act_slot;
                        o.size_out = slot_bytes[act_slot];
                    end
                end
            end
            OP_READ_CNT: begin
                if (r.counter_index < NUM_COUNTERS)
                    o.counter_value = usage_cnt[r.counter_index];
            end
            default: o.status = ST_INVALID_ARG;
        endcase
        return o;
    endfunction

    function automatic request_t req_of(logic [2:0] op, logic [1:0] slot, logic [15:0] size,
                                        logic chk, logic vld, logic [2:0] idx);
        request_t r;
        r.opcode        = op;
        r.packet_slot   = slot;
        r.packet_len    = size;
        r.checked       = chk;
        r.packet_valid  = vld;
        r.counter_index = idx;
        return r;
    endfunction

    function automatic result_t res_of(logic [2:0] st, logic [1:0] slot);
        result_t o;
        o = '0;
        o.status   = st;
        o.slot_out = slot;
        return o;
    endfunction

    function automatic int pick_gap(bit calm);
        int roll;
        roll = $urandom_range(99);
        if (calm || roll < 55)
            return 0;
        else if (roll < 88)
            return $urandom_range(3, 1);
        else
            return $urandom_range(40, 5);
    endfunction

    function automatic logic [15:0] pick_size();
        int roll;
        roll = $urandom_range(99);
        if (lim_min <= lim_max && roll < 75)
            return 16'($urandom_range(lim_max, lim_min));
        else if (roll < 85)
            return lim_min - 16'd1;
        else if (roll < 95)
            return lim_max + 16'd1;
        else
            return 16'($urandom);
    endfunction

    // Mostly well-formed producer and consumer traffic, plus some noise.
    function automatic request_t random_request();
        request_t r;
        int       pick;
        r = request_t'($urandom);
        pick = $urandom_range(99);
        if (pick < 24) begin
            r.opcode = OP_BEGIN_WRITE;
        end else if (pick < 50) begin
            r.opcode = OP_COMMIT;
            if (wr_slot != 2'd0 && $urandom_range(9) != 0)
                r.packet_slot = wr_slot;
            r.packet_len = pick_size();
            r.packet_valid = ($urandom_range(7) != 0);
        end else if (pick < 58) begin
            r.opcode = OP_ABORT;
            if (wr_slot != 2'd0 && $urandom_range(4) != 0)
                r.packet_slot = wr_slot;
        end else if (pick < 80) begin
            r.opcode = OP_ACQUIRE;
        end else if (pick < 92) begin
            r.opcode = OP_READ_CNT;
        end
        return r;
    endfunction

    task automatic row_exp(request_t r, result_t want);
        dir_row_t d;
        d.req   = r;
        d.typed = 1'b1;
        d.want  = want;
        directed_rows.push_back(d);
    endtask

    task automatic row_pred(request_t r);
        dir_row_t d;
        d.req   = r;
        d.typed = 1'b0;
        d.want  = '0;
        directed_rows.push_back(d);
    endtask

    // Present one request after an optional gap and hold it until accepted.
    task automatic issue(request_t r, bit typed, result_t want, int gap);
        result_t predicted;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= r;
        do begin
            @(posedge clk);
        end while (busy);
        predicted = apply_slot_op(r);
        slot_replies_due.push_back(typed ? want : predicted);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (slot_replies_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic set_limits(logic [15:0] max_bytes, logic [15:0] min_bytes);
        wait_drained();
        cfg_write <= 1'b1;
        cfg_index <= CFG_MAX_BYTES;
        cfg_data  <= max_bytes;
        @(posedge clk);
        lim_max = max_bytes;
        cfg_index <= CFG_MIN_BYTES;
        cfg_data  <= min_bytes;
        @(posedge clk);
        lim_min = min_bytes;
        cfg_write <= 1'b0;
    endtask

    // Compare each reply with the oldest one due.
    always @(posedge clk) begin : reply_check
        result_t want;
        if (rst_n && done) begin
            if (slot_replies_due.size() == 0) begin
                $error("reply with none due: status %0d slot %0d", result.status,
                       result.slot_out);
                fail_count++;
            end else begin
                want = slot_replies_due.pop_front();
                if (result.status !== want.status) begin
                    $error("status mismatch: expected %0d, actual %0d", want.status,
                           result.status);
                    fail_count++;
                end
                if (result.slot_out !== want.slot_out) begin
                    $error("slot_out mismatch: expected %0d, actual %0d", want.slot_out,
                           result.slot_out);
                    fail_count++;
                end
                if (result.size_out !== want.size_out) begin
                    $error("size_out mismatch: expected %0d, actual %0d", want.size_out,
                           result.size_out);
                    fail_count++;
                end
                if (result.counter_value !== want.counter_value) begin
                    $error("counter_value mismatch: expected %0d, actual %0d",
                           want.counter_value, result.counter_value);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        int       p;
        int       i;
        int       phase_max [NUM_PHASES];
        int       phase_min [NUM_PHASES];
        dir_row_t d;
        request_t r;
        phase_max = '{65535, 0, 300, 50, 65535, 4096, 0};
        phase_min = '{0, 0, 20, 60, 65535, 16, 0};
        rst_n       = 1'b0;
        start       = 1'b0;
        request     = '0;
        cfg_write   = 1'b0;
        cfg_index   = CFG_MAX_BYTES;
        cfg_data    = '0;
        fail_count  = 0;
        cycle_count = 0;
        free_mask   = ALL_FREE;
        wr_slot     = 2'd0;
        pend_slot   = 2'd0;
        act_slot    = 2'd0;
        ret_slot    = 2'd0;
        mailbox     = 2'd0;
        for (i = 1; i <= 3; i++)
            slot_bytes[i] = '0;
        for (i = 0; i < NUM_COUNTERS; i++)
            usage_cnt[i] = '0;
        lim_max = MAX_BYTES_RESET;
        lim_min = MIN_BYTES_RESET;

        row_exp(req_of(OP_READ_CNT, 2'd0, 16'd0, 1'b0, 1'b0, CNT_NONE), res_of(ST_OK, 2'd0));
        row_exp(req_of(OP_SPARE_FIRST, 2'd1, 16'd0, 1'b0, 1'b0, 3'd0),
                res_of(ST_INVALID_ARG, 2'd0));
        row_exp(req_of(OP_SPARE_LAST, 2'd3, 16'hFFFF, 1'b1, 1'b1, CNT_NONE),
                res_of(ST_INVALID_ARG, 2'd0));
        row_exp(req_of(OP_ACQUIRE, 2'd0, 16'd0, 1'b0, 1'b0, 3'd0),
                res_of(ST_NOT_FOUND, 2'd0));
        row_exp(req_of(OP_ABORT, 2'd0, 16'd0, 1'b0, 1'b0, 3'd0), res_of(ST_STATE_ERR, 2'd0));
        row_exp(req_of(OP_BEGIN_WRITE, 2'd0, 16'd0, 1'b0, 1'b0, 3'd0), res_of(ST_OK, 2'd1));
        row_exp(req_of(OP_BEGIN_WRITE, 2'd0, 16'd0, 1'b0, 1'b0, 3'd0), res_of(ST_BUSY, 2'd0));
        row_exp(req_of(OP_COMMIT, 2'd2, 16'd100, 1'b0, 1'b0, 3'd0),
                res_of(ST_STATE_ERR, 2'd0));
        row_exp(req_of(OP_COMMIT, 2'd1, 16'd15, 1'b0, 1'b0, 3'd0),
                res_of(ST_STATE_ERR, 2'd0));
        row_exp(req_of(OP_COMMIT, 2'd1, 16'd4097, 1'b0, 1'b0, 3'd0),
                res_of(ST_STATE_ERR, 2'd0));
        row_exp(req_of(OP_COMMIT, 2'd1, 16'd16, 1'b1, 1'b0, 3'd0),
                res_of(ST_INVALID_ARG, 2'd0));
        row_exp(req_of(OP_COMMIT, 2'd1, 16'd16, 1'b1, 1'b1, 3'd0), res_of(ST_OK, 2'd0));
        row_pred(req_of(OP_BEGIN_WRITE, 2'd0, 16'd0, 1'b0, 1'b0, 3'd0));
        // replace the pending slot
        row_pred(req_of(OP_COMMIT, 2'd2, 16'd4096, 1'b0, 1'b1, 3'd0));
        row_pred(req_of(OP_ACQUIRE, 2'd0, 16'd0, 1'b0, 1'b0, 3'd0));
        row_pred(req_of(OP_ACQUIRE, 2'd0, 16'd0, 1'b0, 1'b0, 3'd0));
        row_pred(req_of(OP_BEGIN_WRITE, 2'd0, 16'd0, 1'b0, 1'b0, 3'd0));
        row_pred(req_of(OP_COMMIT, 2'd1, 16'd200, 1'b0, 1'b0, 3'd0));
        row_pred(req_of(OP_ACQUIRE, 2'd0, 16'd0, 1'b0, 1'b0, 3'd0));
        row_pred(req_of(OP_BEGIN_WRITE, 2'd0, 16'd0, 1'b0, 1'b0, 3'd0));
        row_exp(req_of(OP_COMMIT, 2'd3, 16'd0, 1'b0, 1'b0, 3'd0), res_of(ST_STATE_ERR, 2'd0));
        row_exp(req_of(OP_COMMIT, 2'd3, 16'hFFFF, 1'b0, 1'b0, 3'd0),
                res_of(ST_STATE_ERR, 2'd0));
        row_pred(req_of(OP_COMMIT, 2'd3, 16'd300, 1'b0, 1'b1, 3'd0));
        // hand the retired slot back, then hit the full mailbox
        row_pred(req_of(OP_ACQUIRE, 2'd0, 16'd0, 1'b0, 1'b0, 3'd0));
        row_exp(req_of(OP_ACQUIRE, 2'd0, 16'd0, 1'b0, 1'b0, 3'd0), res_of(ST_STATE_ERR, 2'd0));
        row_pred(req_of(OP_BEGIN_WRITE, 2'd0, 16'd0, 1'b0, 1'b0, 3'd0));
        row_pred(req_of(OP_ABORT, 2'd2, 16'd0, 1'b0, 1'b0, 3'd0));
        row_pred(req_of(OP_READ_CNT, 2'd0, 16'd0, 1'b0, 1'b0, CNT_BEGINS));
        row_pred(req_of(OP_READ_CNT, 2'd0, 16'd0, 1'b0, 1'b0, CNT_RETURNED));
        row_pred(req_of(OP_READ_CNT, 2'd0, 16'd0, 1'b0, 1'b0, CNT_BUSY));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[k]) begin
            d = directed_rows[k];
            issue(d.req, d.typed, d.want, pick_gap(k < 12));
        end

        for (p = 0; p < NUM_PHASES; p++) begin
            if (p == NUM_PHASES - 1) begin
                phase_max[p] = $urandom_range(65535);
                phase_min[p] = $urandom_range(phase_max[p]);
            end
            set_limits(16'(phase_max[p]), 16'(phase_min[p]));
            for (i = 0; i < PHASE_ITEMS; i++) begin
                r = random_request();
                issue(r, 1'b0, '0, pick_gap((i % 64) < 16));
            end
        end

        wait_drained();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: files.f
hdl/tbsm_pkg.sv
hdl/tbsm_counters.sv
hdl/triple_buffer_slot_manager_top.sv
dv/testbench.sv
